// ===== hdl/ecg_median_burst_sampler_defines.svh =====
// Assertion macros shared by the checker of the median burst sampler.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef ECG_MEDIAN_BURST_SAMPLER_DEFINES_SVH
`define ECG_MEDIAN_BURST_SAMPLER_DEFINES_SVH

// Same-cycle implication, sampled at the rising edge of clk.
`define EMB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled at the rising edge of clk.
`define EMB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/emb_pkg.sv =====
// Shared types and constants of the median burst sampler.
// No dependencies; used by every module of the block except emb_cell.
package emb_pkg;

  localparam int BURST_LEN_DEF    = 5;
  localparam int ADC_BITS_DEF     = 12;
  localparam int PENDING_BITS_DEF = 16;

  localparam int SAT_W     = 12;
  localparam int RETRY_W   = 3;
  localparam int BURSTS_W  = 4;
  localparam int TIME_W    = 64;
  localparam int PLEFT_W   = 16;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic [SAT_W-1:0]   SAT_LOW_RST   = 12'd8;
  localparam logic [SAT_W-1:0]   SAT_HIGH_RST  = 12'd4087;
  localparam logic [RETRY_W-1:0] RETRY_LIM_RST = 3'd3;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CONV = 1'b1;

  typedef enum logic [1:0] {
    REG_SAT_LOW     = 2'd0,
    REG_SAT_HIGH    = 2'd1,
    REG_RETRY_LIMIT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SAT_W-1:0]    sample_value;
    logic                still_saturated;
    logic [BURSTS_W-1:0] bursts_used;
    logic                lead_off_pos;
    logic                lead_off_neg;
    logic [TIME_W-1:0]   sample_time_us;
    logic [PLEFT_W-1:0]  pending_left;
  } result_t;

endpackage

// ===== hdl/emb_cell.sv =====
// One cell of the burst row: holds a conversion and ranks the value it takes in.
// Depends on emb_pkg only through the block's conventions; no types used.
module emb_cell #(
  parameter int BURST_LEN = 5,
  parameter int ADC_BITS  = 12
) (
  input  logic                               clk,
  input  logic                               shift,
  input  logic [ADC_BITS-1:0]                data_in,
  input  logic [BURST_LEN-1:0][ADC_BITS-1:0] cands,
  output logic [ADC_BITS-1:0]                q,
  output logic                               match
);

  localparam int CNT_W = $clog2(BURST_LEN + 1);
  localparam logic [CNT_W-1:0] MID = CNT_W'(BURST_LEN / 2);

  logic [CNT_W-1:0] lt_cnt;
  logic [CNT_W-1:0] le_cnt;

  // The incoming value is the median when no more than MID values lie below
  // it and more than MID values lie at or below it; ties give the same value.
  always_comb begin
    lt_cnt = '0;
    le_cnt = '0;
    for (int j = 0; j < BURST_LEN; j++) begin
      if (cands[j] < data_in) begin
        lt_cnt = lt_cnt + CNT_W'(1);
      end
      if (cands[j] <= data_in) begin
        le_cnt = le_cnt + CNT_W'(1);
      end
    end
  end

  assign match = (lt_cnt <= MID) && (le_cnt > MID);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= data_in;
    end
  end

endmodule

// ===== hdl/emb_out_queue.sv =====
// Two-entry result queue between the burst logic and the result channel.
// Depends on emb_pkg for the result type.
module emb_out_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  emb_pkg::result_t item_in,
  input  logic            stall,
  output logic            valid,
  output emb_pkg::result_t item_out,
  output logic            full
);

  import emb_pkg::*;

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  assign valid    = (count != 2'd0);
  assign full     = (count == 2'd2);
  assign pop      = valid && !stall;
  assign item_out = entries[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

endmodule

// ===== hdl/ecg_median_burst_sampler.sv =====
// Top level of the median burst sampler: control, registers, cell row and queue.
// Depends on emb_pkg, emb_cell and emb_out_queue.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------------------
//  input     | in_valid / in_stall   | req_type, adc_value, lead_off_*, time_us
//  result    | out_valid / out_stall | sample_value ... pending_left
//  config    | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// One item is taken per cycle unless stalled. A conversion that completes a burst
// is ranked across the cell row in the cycle it is taken; unless retried, its
// result enters a two-entry queue; the input stalls only when both are held.
// Reset is synchronous and clears the counters, the flags and the queue.
module ecg_median_burst_sampler #(
  parameter int BURST_LEN    = emb_pkg::BURST_LEN_DEF,
  parameter int ADC_BITS     = emb_pkg::ADC_BITS_DEF,
  parameter int PENDING_BITS = emb_pkg::PENDING_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [ADC_BITS-1:0]           adc_value,
  input  logic                          lead_off_pos,
  input  logic                          lead_off_neg,
  input  logic [emb_pkg::TIME_W-1:0]    time_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [emb_pkg::SAT_W-1:0]     sample_value,
  output logic                          still_saturated,
  output logic [emb_pkg::BURSTS_W-1:0]  bursts_used,
  output logic                          out_lead_off_pos,
  output logic                          out_lead_off_neg,
  output logic [emb_pkg::TIME_W-1:0]    sample_time_us,
  output logic [emb_pkg::PLEFT_W-1:0]   pending_left,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [emb_pkg::APB_AW-1:0]    paddr,
  input  logic [emb_pkg::APB_DW-1:0]    pwdata,
  output logic [emb_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  import emb_pkg::*;

  localparam int POS_W = $clog2(BURST_LEN);
  localparam int CMP_W = (ADC_BITS > SAT_W) ? ADC_BITS : SAT_W;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BURST_LEN - 1);

  // Configuration registers
  logic [SAT_W-1:0]   sat_low;
  logic [SAT_W-1:0]   sat_high;
  logic [RETRY_W-1:0] retry_limit;
  logic               cfg_write;
  reg_idx_t           reg_idx;

  // Control state
  logic [PENDING_BITS-1:0] pending;
  logic [PENDING_BITS-1:0] pending_next;
  logic [PENDING_BITS-1:0] pend_after;
  logic                    active;
  logic                    active_next;
  logic [POS_W-1:0]        pos;
  logic [POS_W-1:0]        pos_next;
  logic [RETRY_W-1:0]      retries;
  logic [RETRY_W-1:0]      retries_next;

  logic accept;
  logic is_conv;
  logic starting;
  logic taking;
  logic burst_done;
  logic saturated;
  logic retry;
  logic push;

  logic [BURST_LEN-1:0][ADC_BITS-1:0] cands;
  logic [ADC_BITS-1:0]                cell_q [BURST_LEN-1];
  logic [BURST_LEN-1:0]               match;
  logic [ADC_BITS-1:0]                median;
  logic [ADC_BITS+SAT_W-1:0]          median_wide;
  logic [PENDING_BITS+PLEFT_W-1:0]    pend_wide;

  result_t res;
  result_t q_item;
  logic    q_full;

  // ---------------------------------------------------------------------------
  // Register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_low     <= SAT_LOW_RST;
      sat_high    <= SAT_HIGH_RST;
      retry_limit <= RETRY_LIM_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_SAT_LOW:     sat_low     <= pwdata[SAT_W-1:0];
        REG_SAT_HIGH:    sat_high    <= pwdata[SAT_W-1:0];
        REG_RETRY_LIMIT: retry_limit <= pwdata[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SAT_LOW:     prdata = APB_DW'(sat_low);
      REG_SAT_HIGH:    prdata = APB_DW'(sat_high);
      REG_RETRY_LIMIT: prdata = APB_DW'(retry_limit);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Cell row: every taken conversion enters cell 0 and the row moves along.
  for (genvar i = 0; i < BURST_LEN; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cands[i] = adc_value;
    end else begin : g_body
      assign cands[i] = cell_q[i-1];
    end
    if (i < BURST_LEN - 1) begin : g_keep
      emb_cell #(
        .BURST_LEN (BURST_LEN),
        .ADC_BITS  (ADC_BITS)
      ) u_cell (
        .clk     (clk),
        .shift   (taking),
        .data_in (cands[i]),
        .cands   (cands),
        .q       (cell_q[i]),
        .match   (match[i])
      );
    end else begin : g_tail
      // The oldest value leaves the row here and is only ranked.
      emb_cell #(
        .BURST_LEN (BURST_LEN),
        .ADC_BITS  (ADC_BITS)
      ) u_cell (
        .clk     (clk),
        .shift   (taking),
        .data_in (cands[i]),
        .cands   (cands),
        .q       (),
        .match   (match[i])
      );
    end
  end

  // All matching cells hold the same value, so an OR picks it out.
  always_comb begin
    median = '0;
    for (int i = 0; i < BURST_LEN; i++) begin
      if (match[i]) begin
        median = median | cands[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample control
  assign accept     = in_valid && !in_stall;
  assign is_conv    = (req_type == REQ_CONV);
  assign starting   = !active && (pending != '0);
  assign taking     = accept && is_conv && (active || starting);
  assign burst_done = (pos == LAST_POS);
  assign pend_after = starting ? (pending - PENDING_BITS'(1)) : pending;

  assign saturated = (CMP_W'(median) <= CMP_W'(sat_low)) ||
                     (CMP_W'(median) >= CMP_W'(sat_high));
  assign retry     = saturated && (retries < retry_limit);
  assign push      = taking && burst_done && !retry;

  always_comb begin
    pending_next = pending;
    active_next  = active;
    pos_next     = pos;
    retries_next = retries;
    if (accept) begin
      if (!is_conv) begin
        if (pending != '1) begin
          pending_next = pending + PENDING_BITS'(1);
        end
      end else if (active || starting) begin
        pending_next = pend_after;
        if (!burst_done) begin
          pos_next    = pos + POS_W'(1);
          active_next = 1'b1;
        end else begin
          pos_next = '0;
          if (retry) begin
            retries_next = retries + RETRY_W'(1);
            active_next  = 1'b1;
          end else begin
            retries_next = '0;
            active_next  = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      active  <= 1'b0;
      pos     <= '0;
      retries <= '0;
    end else begin
      pending <= pending_next;
      active  <= active_next;
      pos     <= pos_next;
      retries <= retries_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result assembly and queue
  assign median_wide = {{SAT_W{1'b0}}, median};
  assign pend_wide   = {{PLEFT_W{1'b0}}, pend_after};

  always_comb begin
    res.sample_value    = median_wide[SAT_W-1:0];
    res.still_saturated = saturated;
    res.bursts_used     = {1'b0, retries} + BURSTS_W'(1);
    res.lead_off_pos    = lead_off_pos;
    res.lead_off_neg    = lead_off_neg;
    res.sample_time_us  = time_us;
    res.pending_left    = pend_wide[PLEFT_W-1:0];
  end

  emb_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (res),
    .stall    (out_stall),
    .valid    (out_valid),
    .item_out (q_item),
    .full     (q_full)
  );

  assign in_stall         = q_full;
  assign sample_value     = q_item.sample_value;
  assign still_saturated  = q_item.still_saturated;
  assign bursts_used      = q_item.bursts_used;
  assign out_lead_off_pos = q_item.lead_off_pos;
  assign out_lead_off_neg = q_item.lead_off_neg;
  assign sample_time_us   = q_item.sample_time_us;
  assign pending_left     = q_item.pending_left;

endmodule

// ===== hdl/emb_checker.sv =====
// Port-level checks of the median burst sampler, bound to its top level.
// Depends on ecg_median_burst_sampler_defines.svh and emb_pkg.
`include "ecg_median_burst_sampler_defines.svh"

module emb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [emb_pkg::SAT_W-1:0]   sample_value,
  input logic                        still_saturated,
  input logic [emb_pkg::TIME_W-1:0]  sample_time_us
);

  // A stalled result stays offered.
  `EMB_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "stalled result withdrawn")

  // A stalled result keeps its payload.
  `EMB_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(sample_value) && $stable(still_saturated) && $stable(sample_time_us), "stalled result changed")

  // A new result only follows an input transfer on the previous edge.
  `EMB_ASSERT_NOW(a_out_cause, out_valid && !$past(out_valid), $past(in_valid && !in_stall), "result without an input transfer")

  // With no result held, there is room in the queue and the input is open.
  `EMB_ASSERT_NOW(a_in_open, !out_valid, !in_stall, "input stalled with empty queue")

endmodule

bind ecg_median_burst_sampler emb_checker u_emb_checker (.*);
